// ===== hw/rtl/crwsa_pkg.sv =====
// Package: shared constants, codes and types of the clock replacement working-set allocator.
`timescale 1ns / 1ps
package crwsa_pkg;

   localparam int MAX_PROCS           = 8;
   localparam int PROC_BITS           = 3;
   localparam int MAX_FRAMES_PER_PROC = 64;
   localparam int FRAME_BITS          = 6;
   localparam int LOG_DEPTH           = 64;
   localparam int LOG_BITS            = 6;
   localparam int PAGE_BITS           = 20;
   localparam int ADDR_BITS           = PROC_BITS + FRAME_BITS;
   localparam int LOG_ADDR_BITS       = PROC_BITS + LOG_BITS;
   localparam int SLOT_TOTAL          = MAX_PROCS * MAX_FRAMES_PER_PROC;
   localparam int LOG_TOTAL           = MAX_PROCS * LOG_DEPTH;
   localparam int TG_BITS             = 13;
   localparam int DIV_STEPS           = 16;

   localparam logic [9:0] TOTAL_FRAMES_RST    = 10'd64;
   localparam logic [3:0] PROCESS_COUNT_RST   = 4'd4;
   localparam logic [6:0] INTERVAL_LENGTH_RST = 7'd16;

   typedef enum logic [2:0] {
      ACT_HIT      = 3'd0,
      ACT_CLOCK    = 3'd1,
      ACT_OWN      = 3'd2,
      ACT_POOL     = 3'd3,
      ACT_DONOR    = 3'd4,
      ACT_UNPLACED = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      CSR_TOTAL_FRAMES    = 2'd0,
      CSR_PROCESS_COUNT   = 2'd1,
      CSR_INTERVAL_LENGTH = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_INIT_DIV,
      ST_IDLE,
      ST_PREP,
      ST_SEARCH,
      ST_TSUM,
      ST_DECIDE,
      ST_CLK_START,
      ST_CLK_RD,
      ST_CLK_CHK,
      ST_PLACE,
      ST_LOG,
      ST_RC_PROC,
      ST_RC_RDP,
      ST_RC_SCAN,
      ST_Q_START,
      ST_Q_DIV,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/crwsa_if.sv =====
// Interfaces: request, response and register write channels of the allocator.
`timescale 1ns / 1ps
interface crwsa_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  process_id;
   logic [19:0] page_number;

   modport source (output valid, output process_id, output page_number, input ready);
   modport sink   (input valid, input process_id, input page_number, output ready);
endinterface

interface crwsa_rsp_if;
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [5:0]             slot;
   crwsa_pkg::action_type  action;
   logic [2:0]             donor;
   logic                   interval_end;
   logic [31:0]            ref_count;
   logic [31:0]            fault_count;

   modport source (output valid, output hit, output slot, output action, output donor,
                   output interval_end, output ref_count, output fault_count, input ready);
   modport sink   (input valid, input hit, input slot, input action, input donor,
                   input interval_end, input ref_count, input fault_count, output ready);
endinterface

interface crwsa_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [9:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/clock_replacement_working_set_alloc_core.sv =====
// Top level: working-set page allocator with second-chance clock replacement.
// A hit searches the resident set of its process; a fault adds a scan over the live processes
// and the slots the clock hand visits. An interval end adds, per process, resident-set/log
// matching and a serial quota division.
// One request at a time; the resident and log memory ports set the pace.
// Reset and writes to total_frames or process_count run a clear of all reference bits
// and an initial divide before the first request is taken.
`timescale 1ns / 1ps
module clock_replacement_working_set_alloc_core (
   input  logic clock,
   input  logic reset,
   crwsa_req_if.sink   req_chan,
   crwsa_rsp_if.source rsp_chan,
   crwsa_csr_if.sink   csr_chan
);

   localparam int NP = crwsa_pkg::MAX_PROCS;
   localparam int PB = crwsa_pkg::PROC_BITS;
   localparam int FB = crwsa_pkg::FRAME_BITS;
   localparam int LB = crwsa_pkg::LOG_BITS;
   localparam int AB = crwsa_pkg::ADDR_BITS;
   localparam int GB = crwsa_pkg::LOG_ADDR_BITS;
   localparam int WB = crwsa_pkg::PAGE_BITS;
   localparam int TB = crwsa_pkg::TG_BITS;

   crwsa_pkg::state_type state_ff, state_in;

   logic [9:0] tf_ff, tf_in;
   logic [3:0] pc_ff, pc_in;
   logic [6:0] il_ff, il_in;
   logic [3:0] n_live;

   logic [6:0]  used_ff  [NP], used_in  [NP];
   logic [6:0]  limit_ff [NP], limit_in [NP];
   logic [9:0]  gr_ff    [NP], gr_in    [NP];
   logic [6:0]  hand_ff  [NP], hand_in  [NP];
   logic [31:0] hits_ff  [NP], hits_in  [NP];
   logic [31:0] miss_ff  [NP], miss_in  [NP];
   logic [6:0]  logc_ff  [NP], logc_in  [NP];
   logic [6:0]  seen_ff  [NP], seen_in  [NP];
   logic [6:0]  ic_ff, ic_in;

   logic [PB-1:0] p_ff, p_in;
   logic [WB-1:0] page_ff, page_in;
   logic [6:0]    i_ff, i_in;
   logic [6:0]    k_ff, k_in;
   logic [3:0]    j_ff, j_in;
   logic          cmp_vld_ff, cmp_vld_in;
   logic [5:0]    cmp_idx_ff, cmp_idx_in;
   logic [TB-1:0] tg_ff, tg_in;
   logic          dfound_ff, dfound_in;
   logic [PB-1:0] dnr_ff, dnr_in;
   logic [6:0]    clk_n_ff, clk_n_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic [9:0]    total_ff, total_in;
   logic [AB-1:0] clr_ff, clr_in;

   logic [9:0]  div_rem_ff, div_rem_in;
   logic [15:0] div_quo_ff, div_quo_in;
   logic [9:0]  div_den_ff, div_den_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic [10:0] div_try;
   logic        div_ge;
   logic [9:0]  div_rem_nx;
   logic [15:0] div_quo_nx;
   logic [16:0] mul_prod;

   logic                  res_hit_ff, res_hit_in;
   logic [5:0]            res_slot_ff, res_slot_in;
   crwsa_pkg::action_type res_act_ff, res_act_in;
   logic [2:0]            res_dnr_ff, res_dnr_in;
   logic                  res_iend_ff, res_iend_in;
   logic                  res_oor_ff, res_oor_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [5:0]            rsp_slot_ff, rsp_slot_in;
   crwsa_pkg::action_type rsp_act_ff, rsp_act_in;
   logic [2:0]            rsp_dnr_ff, rsp_dnr_in;
   logic                  rsp_iend_ff, rsp_iend_in;
   logic [31:0]           rsp_refs_ff, rsp_refs_in;
   logic [31:0]           rsp_flt_ff, rsp_flt_in;
   logic [32:0]           refs_sum;

   logic [WB-1:0] rp_mem [crwsa_pkg::SLOT_TOTAL];
   logic          rp_we, rp_re;
   logic [AB-1:0] rp_waddr, rp_raddr;
   logic [WB-1:0] rp_rdata_ff;

   logic          rb_mem [crwsa_pkg::SLOT_TOTAL];
   logic          rb_we, rb_wdata, rb_re;
   logic [AB-1:0] rb_waddr, rb_raddr;
   logic          rb_rdata_ff;

   logic [WB-1:0] lg_mem [crwsa_pkg::LOG_TOTAL];
   logic          lg_we, lg_re;
   logic [GB-1:0] lg_waddr, lg_raddr;
   logic [WB-1:0] lg_rdata_ff;

   logic       srch_match, scan_match;
   logic [6:0] ic_nx;
   logic [6:0] cu, cl;
   logic [9:0] cg;

   always_ff @(posedge clock) begin
      if (rp_we) rp_mem[rp_waddr] <= page_ff;
      if (rp_re) rp_rdata_ff <= rp_mem[rp_raddr];
   end

   always_ff @(posedge clock) begin
      if (rb_we) rb_mem[rb_waddr] <= rb_wdata;
      if (rb_re) rb_rdata_ff <= rb_mem[rb_raddr];
   end

   always_ff @(posedge clock) begin
      if (lg_we) lg_mem[lg_waddr] <= page_ff;
      if (lg_re) lg_rdata_ff <= lg_mem[lg_raddr];
   end

   always_comb begin
      if (pc_ff == 4'd0) begin
         n_live = 4'd1;
      end else if (pc_ff > 4'(NP)) begin
         n_live = 4'(NP);
      end else begin
         n_live = pc_ff;
      end
   end

   assign div_try    = {div_rem_ff, div_quo_ff[15]};
   assign div_ge     = div_try >= {1'b0, div_den_ff};
   assign div_rem_nx = div_ge ? 10'(div_try - {1'b0, div_den_ff}) : div_try[9:0];
   assign div_quo_nx = {div_quo_ff[14:0], div_ge};
   assign mul_prod   = 17'(seen_ff[j_ff[PB-1:0]]) * 17'(tf_ff);

   assign srch_match = cmp_vld_ff && (rp_rdata_ff == page_ff);
   assign scan_match = cmp_vld_ff && (lg_rdata_ff == rp_rdata_ff);
   assign ic_nx      = ic_ff + 7'd1;
   assign cu         = used_ff[p_ff];
   assign cl         = limit_ff[p_ff];
   assign cg         = gr_ff[p_ff];
   assign refs_sum   = {1'b0, hits_ff[p_ff]} + {1'b0, miss_ff[p_ff]};

   assign req_chan.ready        = (state_ff == crwsa_pkg::ST_IDLE);
   assign csr_chan.ready        = 1'b1;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit          = rsp_hit_ff;
   assign rsp_chan.slot         = rsp_slot_ff;
   assign rsp_chan.action       = rsp_act_ff;
   assign rsp_chan.donor        = rsp_dnr_ff;
   assign rsp_chan.interval_end = rsp_iend_ff;
   assign rsp_chan.ref_count    = rsp_refs_ff;
   assign rsp_chan.fault_count  = rsp_flt_ff;

   always_comb begin
      state_in   = state_ff;
      tf_in      = tf_ff;
      pc_in      = pc_ff;
      il_in      = il_ff;
      used_in    = used_ff;
      limit_in   = limit_ff;
      gr_in      = gr_ff;
      hand_in    = hand_ff;
      hits_in    = hits_ff;
      miss_in    = miss_ff;
      logc_in    = logc_ff;
      seen_in    = seen_ff;
      ic_in      = ic_ff;
      p_in       = p_ff;
      page_in    = page_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      j_in       = j_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      tg_in      = tg_ff;
      dfound_in  = dfound_ff;
      dnr_in     = dnr_ff;
      clk_n_in   = clk_n_ff;
      cnt_in     = cnt_ff;
      total_in   = total_ff;
      clr_in     = clr_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      res_hit_in  = res_hit_ff;
      res_slot_in = res_slot_ff;
      res_act_in  = res_act_ff;
      res_dnr_in  = res_dnr_ff;
      res_iend_in = res_iend_ff;
      res_oor_in  = res_oor_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_dnr_in   = rsp_dnr_ff;
      rsp_iend_in  = rsp_iend_ff;
      rsp_refs_in  = rsp_refs_ff;
      rsp_flt_in   = rsp_flt_ff;
      rp_we    = 1'b0;
      rp_re    = 1'b0;
      rp_waddr = {p_ff, FB'(0)};
      rp_raddr = {p_ff, i_ff[FB-1:0]};
      rb_we    = 1'b0;
      rb_wdata = 1'b0;
      rb_re    = 1'b0;
      rb_waddr = {p_ff, FB'(0)};
      rb_raddr = {p_ff, hand_ff[p_ff][FB-1:0]};
      lg_we    = 1'b0;
      lg_re    = 1'b0;
      lg_waddr = {p_ff, logc_ff[p_ff][LB-1:0]};
      lg_raddr = {j_ff[PB-1:0], k_ff[LB-1:0]};

      case (state_ff)
         crwsa_pkg::ST_CLEAR: begin
            rb_we    = 1'b1;
            rb_waddr = clr_ff;
            clr_in   = clr_ff + AB'(1);
            if (clr_ff == AB'(crwsa_pkg::SLOT_TOTAL - 1)) begin
               div_rem_in = 10'd0;
               div_quo_in = {6'd0, tf_ff};
               div_den_in = {6'd0, n_live};
               div_cnt_in = 5'd0;
               state_in   = crwsa_pkg::ST_INIT_DIV;
            end
         end
         crwsa_pkg::ST_INIT_DIV: begin
            if (div_cnt_ff == 5'(crwsa_pkg::DIV_STEPS)) begin
               for (int q = 0; q < NP; q++) begin
                  gr_in[q]    = div_quo_ff[9:0];
                  limit_in[q] = (div_quo_ff > 16'(crwsa_pkg::MAX_FRAMES_PER_PROC)) ?
                                7'(crwsa_pkg::MAX_FRAMES_PER_PROC) : div_quo_ff[6:0];
               end
               state_in = crwsa_pkg::ST_IDLE;
            end else begin
               div_rem_in = div_rem_nx;
               div_quo_in = div_quo_nx;
               div_cnt_in = div_cnt_ff + 5'd1;
            end
         end
         crwsa_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               p_in        = req_chan.process_id;
               page_in     = req_chan.page_number;
               res_hit_in  = 1'b0;
               res_slot_in = 6'd0;
               res_act_in  = crwsa_pkg::ACT_UNPLACED;
               res_dnr_in  = 3'd0;
               res_iend_in = 1'b0;
               res_oor_in  = ({1'b0, req_chan.process_id} >= n_live);
               state_in    = ({1'b0, req_chan.process_id} >= n_live) ?
                             crwsa_pkg::ST_DONE : crwsa_pkg::ST_PREP;
            end
         end
         crwsa_pkg::ST_PREP: begin
            if (hand_ff[p_ff] >= cl) hand_in[p_ff] = 7'd0;
            if (cu > cl) used_in[p_ff] = cl;
            i_in     = 7'd0;
            state_in = crwsa_pkg::ST_SEARCH;
         end
         crwsa_pkg::ST_SEARCH: begin
            if (srch_match) begin
               rb_we    = 1'b1;
               rb_wdata = 1'b1;
               rb_waddr = {p_ff, cmp_idx_ff[FB-1:0]};
               if (hits_ff[p_ff] != 32'hFFFF_FFFF) hits_in[p_ff] = hits_ff[p_ff] + 32'd1;
               res_hit_in  = 1'b1;
               res_slot_in = cmp_idx_ff;
               res_act_in  = crwsa_pkg::ACT_HIT;
               state_in    = crwsa_pkg::ST_LOG;
            end else if (i_ff < cu) begin
               rp_re      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = i_ff[5:0];
               i_in       = i_ff + 7'd1;
            end else begin
               if (miss_ff[p_ff] != 32'hFFFF_FFFF) miss_in[p_ff] = miss_ff[p_ff] + 32'd1;
               j_in      = 4'd0;
               tg_in     = TB'(0);
               dfound_in = 1'b0;
               state_in  = crwsa_pkg::ST_TSUM;
            end
         end
         crwsa_pkg::ST_TSUM: begin
            if (j_ff < n_live) begin
               tg_in = tg_ff + TB'(gr_ff[j_ff[PB-1:0]]);
               if (!dfound_ff && ({3'd0, limit_ff[j_ff[PB-1:0]]} < gr_ff[j_ff[PB-1:0]]) &&
                   (gr_ff[j_ff[PB-1:0]] > 10'd1)) begin
                  dfound_in = 1'b1;
                  dnr_in    = j_ff[PB-1:0];
               end
               j_in = j_ff + 4'd1;
            end else begin
               state_in = crwsa_pkg::ST_DECIDE;
            end
         end
         crwsa_pkg::ST_DECIDE: begin
            if (cu == cl) begin
               clk_n_in = cl;
               state_in = crwsa_pkg::ST_CLK_START;
            end else if ((cu < cl) && ({3'd0, cu} < cg)) begin
               res_act_in = crwsa_pkg::ACT_OWN;
               state_in   = crwsa_pkg::ST_PLACE;
            end else if ((tg_ff < TB'(tf_ff)) && ({3'd0, cl} > cg) && ({3'd0, cu} == cg)) begin
               gr_in[p_ff] = cg + 10'd1;
               res_act_in  = crwsa_pkg::ACT_POOL;
               state_in    = crwsa_pkg::ST_PLACE;
            end else if (({3'd0, cu} == cg) && (cg < {3'd0, cl})) begin
               if (dfound_ff) begin
                  gr_in[dnr_ff] = gr_ff[dnr_ff] - 10'd1;
                  gr_in[p_ff]   = cg + 10'd1;
                  res_act_in    = crwsa_pkg::ACT_DONOR;
                  res_dnr_in    = dnr_ff;
                  state_in      = crwsa_pkg::ST_PLACE;
               end else begin
                  clk_n_in = cu;
                  state_in = crwsa_pkg::ST_CLK_START;
               end
            end else begin
               state_in = crwsa_pkg::ST_LOG;
            end
         end
         crwsa_pkg::ST_CLK_START: begin
            if (clk_n_ff == 7'd0) begin
               state_in = crwsa_pkg::ST_LOG;
            end else begin
               if (hand_ff[p_ff] >= clk_n_ff) hand_in[p_ff] = 7'd0;
               state_in = crwsa_pkg::ST_CLK_RD;
            end
         end
         crwsa_pkg::ST_CLK_RD: begin
            rb_re    = 1'b1;
            state_in = crwsa_pkg::ST_CLK_CHK;
         end
         crwsa_pkg::ST_CLK_CHK: begin
            if (!rb_rdata_ff) begin
               rp_we         = 1'b1;
               rp_waddr      = {p_ff, hand_ff[p_ff][FB-1:0]};
               hand_in[p_ff] = hand_ff[p_ff] + 7'd1;
               res_slot_in   = hand_ff[p_ff][5:0];
               res_act_in    = crwsa_pkg::ACT_CLOCK;
               state_in      = crwsa_pkg::ST_LOG;
            end else begin
               rb_we         = 1'b1;
               rb_wdata      = 1'b0;
               rb_waddr      = {p_ff, hand_ff[p_ff][FB-1:0]};
               hand_in[p_ff] = ((hand_ff[p_ff] + 7'd1) >= clk_n_ff) ? 7'd0 :
                               hand_ff[p_ff] + 7'd1;
               state_in      = crwsa_pkg::ST_CLK_RD;
            end
         end
         crwsa_pkg::ST_PLACE: begin
            rp_we         = 1'b1;
            rp_waddr      = {p_ff, cu[FB-1:0]};
            rb_we         = 1'b1;
            rb_wdata      = 1'b0;
            rb_waddr      = {p_ff, cu[FB-1:0]};
            used_in[p_ff] = cu + 7'd1;
            res_slot_in   = cu[5:0];
            state_in      = crwsa_pkg::ST_LOG;
         end
         crwsa_pkg::ST_LOG: begin
            if (logc_ff[p_ff] < 7'(crwsa_pkg::LOG_DEPTH)) begin
               lg_we         = 1'b1;
               logc_in[p_ff] = logc_ff[p_ff] + 7'd1;
            end
            if (ic_nx == il_ff) begin
               ic_in       = 7'd0;
               res_iend_in = 1'b1;
               j_in        = 4'd0;
               total_in    = 10'd0;
               state_in    = crwsa_pkg::ST_RC_PROC;
            end else begin
               ic_in    = ic_nx;
               state_in = crwsa_pkg::ST_DONE;
            end
         end
         crwsa_pkg::ST_RC_PROC: begin
            if (j_ff < n_live) begin
               cnt_in   = 7'd0;
               i_in     = 7'd0;
               state_in = crwsa_pkg::ST_RC_RDP;
            end else begin
               j_in     = 4'd0;
               state_in = crwsa_pkg::ST_Q_START;
            end
         end
         crwsa_pkg::ST_RC_RDP: begin
            if (i_ff < used_ff[j_ff[PB-1:0]]) begin
               rp_re    = 1'b1;
               rp_raddr = {j_ff[PB-1:0], i_ff[FB-1:0]};
               k_in     = 7'd0;
               state_in = crwsa_pkg::ST_RC_SCAN;
            end else begin
               seen_in[j_ff[PB-1:0]] = cnt_ff;
               total_in = total_ff + {3'd0, cnt_ff};
               j_in     = j_ff + 4'd1;
               state_in = crwsa_pkg::ST_RC_PROC;
            end
         end
         crwsa_pkg::ST_RC_SCAN: begin
            if (scan_match) begin
               cnt_in   = cnt_ff + 7'd1;
               i_in     = i_ff + 7'd1;
               state_in = crwsa_pkg::ST_RC_RDP;
            end else if (k_ff < logc_ff[j_ff[PB-1:0]]) begin
               lg_re      = 1'b1;
               cmp_vld_in = 1'b1;
               k_in       = k_ff + 7'd1;
            end else begin
               i_in     = i_ff + 7'd1;
               state_in = crwsa_pkg::ST_RC_RDP;
            end
         end
         crwsa_pkg::ST_Q_START: begin
            if (j_ff < n_live) begin
               div_rem_in = 10'd0;
               div_quo_in = mul_prod[15:0];
               div_den_in = (total_ff == 10'd0) ? 10'd1 : total_ff;
               div_cnt_in = 5'd0;
               state_in   = crwsa_pkg::ST_Q_DIV;
            end else begin
               state_in = crwsa_pkg::ST_DONE;
            end
         end
         crwsa_pkg::ST_Q_DIV: begin
            if (div_cnt_ff == 5'(crwsa_pkg::DIV_STEPS)) begin
               if (div_quo_ff == 16'd0) begin
                  limit_in[j_ff[PB-1:0]] = 7'd1;
               end else if (div_quo_ff > 16'(crwsa_pkg::MAX_FRAMES_PER_PROC)) begin
                  limit_in[j_ff[PB-1:0]] = 7'(crwsa_pkg::MAX_FRAMES_PER_PROC);
               end else begin
                  limit_in[j_ff[PB-1:0]] = div_quo_ff[6:0];
               end
               logc_in[j_ff[PB-1:0]] = 7'd0;
               j_in     = j_ff + 4'd1;
               state_in = crwsa_pkg::ST_Q_START;
            end else begin
               div_rem_in = div_rem_nx;
               div_quo_in = div_quo_nx;
               div_cnt_in = div_cnt_ff + 5'd1;
            end
         end
         crwsa_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_slot_in  = res_slot_ff;
               rsp_act_in   = res_act_ff;
               rsp_dnr_in   = res_dnr_ff;
               rsp_iend_in  = res_iend_ff;
               rsp_refs_in  = res_oor_ff ? 32'd0 :
                              (refs_sum[32] ? 32'hFFFF_FFFF : refs_sum[31:0]);
               rsp_flt_in   = res_oor_ff ? 32'd0 : miss_ff[p_ff];
               state_in     = crwsa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crwsa_pkg::ST_IDLE;
         end
      endcase

      if (csr_chan.valid) begin
         case (csr_chan.index)
            crwsa_pkg::CSR_TOTAL_FRAMES,
            crwsa_pkg::CSR_PROCESS_COUNT: begin
               if (csr_chan.index == crwsa_pkg::CSR_TOTAL_FRAMES) begin
                  tf_in = csr_chan.data;
               end else begin
                  pc_in = csr_chan.data[3:0];
               end
               for (int q = 0; q < NP; q++) begin
                  used_in[q] = 7'd0;
                  hand_in[q] = 7'd0;
                  hits_in[q] = 32'd0;
                  miss_in[q] = 32'd0;
                  logc_in[q] = 7'd0;
               end
               ic_in    = 7'd0;
               clr_in   = AB'(0);
               state_in = crwsa_pkg::ST_CLEAR;
            end
            crwsa_pkg::CSR_INTERVAL_LENGTH: begin
               il_in = csr_chan.data[6:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crwsa_pkg::ST_CLEAR;
         tf_ff        <= crwsa_pkg::TOTAL_FRAMES_RST;
         pc_ff        <= crwsa_pkg::PROCESS_COUNT_RST;
         il_ff        <= crwsa_pkg::INTERVAL_LENGTH_RST;
         ic_ff        <= 7'd0;
         clr_ff       <= AB'(0);
         rsp_valid_ff <= 1'b0;
         for (int q = 0; q < NP; q++) begin
            used_ff[q]  <= 7'd0;
            limit_ff[q] <= 7'd0;
            gr_ff[q]    <= 10'd0;
            hand_ff[q]  <= 7'd0;
            hits_ff[q]  <= 32'd0;
            miss_ff[q]  <= 32'd0;
            logc_ff[q]  <= 7'd0;
         end
      end else begin
         state_ff     <= state_in;
         tf_ff        <= tf_in;
         pc_ff        <= pc_in;
         il_ff        <= il_in;
         ic_ff        <= ic_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
         limit_ff     <= limit_in;
         gr_ff        <= gr_in;
         hand_ff      <= hand_in;
         hits_ff      <= hits_in;
         miss_ff      <= miss_in;
         logc_ff      <= logc_in;
      end
   end

   always_ff @(posedge clock) begin
      seen_ff     <= seen_in;
      p_ff        <= p_in;
      page_ff     <= page_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      cmp_vld_ff  <= cmp_vld_in;
      cmp_idx_ff  <= cmp_idx_in;
      tg_ff       <= tg_in;
      dfound_ff   <= dfound_in;
      dnr_ff      <= dnr_in;
      clk_n_ff    <= clk_n_in;
      cnt_ff      <= cnt_in;
      total_ff    <= total_in;
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_den_ff  <= div_den_in;
      div_cnt_ff  <= div_cnt_in;
      res_hit_ff  <= res_hit_in;
      res_slot_ff <= res_slot_in;
      res_act_ff  <= res_act_in;
      res_dnr_ff  <= res_dnr_in;
      res_iend_ff <= res_iend_in;
      res_oor_ff  <= res_oor_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_dnr_ff  <= rsp_dnr_in;
      rsp_iend_ff <= rsp_iend_in;
      rsp_refs_ff <= rsp_refs_in;
      rsp_flt_ff  <= rsp_flt_in;
   end

endmodule
